// ===== src/vdphp_pkg.sv =====
// ----------------------------------------------------------------------------
// vdphp_pkg
// Shared types and constants for the display processor host port and the
// frame timing unit: request codes, raster constants and control words.
// ----------------------------------------------------------------------------
package vdphp_pkg;

	// Default sizes, handed down from the top level.
	localparam int VramDepthDef     = 16384;
	localparam int ColsPerLineDef   = 342;
	localparam int LinesPerFrameDef = 262;

	// Field widths.
	localparam int ReqW  = 3;
	localparam int ByteW = 8;
	localparam int AddrW = 14;

	// Request codes carried on the input kind field.
	localparam logic [ReqW-1:0] REQ_TICK       = 3'd0;
	localparam logic [ReqW-1:0] REQ_DATA_READ  = 3'd1;
	localparam logic [ReqW-1:0] REQ_STAT_READ  = 3'd2;
	localparam logic [ReqW-1:0] REQ_DATA_WRITE = 3'd3;
	localparam logic [ReqW-1:0] REQ_CTRL_WRITE = 3'd4;

	// Mode register that holds the interrupt enable.
	localparam logic [2:0] REG_IE = 3'd1;

	// Raster events.
	localparam int VblankLine   = 219;
	localparam int FrameEndLine = 243;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_FETCH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // a word is taken from the input this cycle
		logic capture;  // VRAM read data is valid, load the read-ahead buffer
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_fetch; // the offered word needs a VRAM prefetch
	} status_t;

endpackage

// ===== src/vdphp_vram.sv =====
// ----------------------------------------------------------------------------
// vdphp_vram
// Single-port video memory with a registered read port.
// ----------------------------------------------------------------------------
module vdphp_vram #(
	parameter int VRAM_DEPTH = vdphp_pkg::VramDepthDef
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic                          re,
	input  logic [$clog2(VRAM_DEPTH)-1:0] addr,
	input  logic [vdphp_pkg::ByteW-1:0]   wdata,
	output logic [vdphp_pkg::ByteW-1:0]   rdata
);
	import vdphp_pkg::*;

	logic [ByteW-1:0] mem_q [VRAM_DEPTH];
	logic [ByteW-1:0] rdata_q;

	// Write and registered read share the one address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/vdphp_ctrl.sv =====
// ----------------------------------------------------------------------------
// vdphp_ctrl
// Controller: input and output handshakes and the prefetch wait state.
// ----------------------------------------------------------------------------
module vdphp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  vdphp_pkg::status_t stat,
	output vdphp_pkg::cmd_t    cmd
);
	import vdphp_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   accept;

	// A word is taken when idle and the result register is free or being emptied.
	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && stat.need_fetch) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = accept;
			end
			ST_FETCH: begin
				cmd.capture = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Input is only taken in the idle state.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("input ready outside the idle state");

	// A prefetching word moves the controller to the wait state.
	a_fetch_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && stat.need_fetch) |=> state_q == ST_FETCH)
		else $error("prefetch did not enter the wait state");

	// The wait state is always followed by the idle state.
	a_fetch_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |=> state_q == ST_IDLE)
		else $error("prefetch wait longer than one cycle");

	// Every accepted word leaves a result behind.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid_q)
		else $error("accepted word produced no result");

endmodule

// ===== src/vdphp_datapath.sv =====
// ----------------------------------------------------------------------------
// vdphp_datapath
// Datapath: access address, read-ahead buffer, command byte latch, status
// flag, raster counters, result register and the video memory.
// ----------------------------------------------------------------------------
module vdphp_datapath #(
	parameter int VRAM_DEPTH      = vdphp_pkg::VramDepthDef,
	parameter int COLS_PER_LINE   = vdphp_pkg::ColsPerLineDef,
	parameter int LINES_PER_FRAME = vdphp_pkg::LinesPerFrameDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vdphp_pkg::cmd_t             cmd,
	output vdphp_pkg::status_t          stat,
	input  logic [vdphp_pkg::ReqW-1:0]  s_tuser,
	input  logic [vdphp_pkg::ByteW-1:0] s_tdata,
	output logic [vdphp_pkg::ByteW-1:0] m_tdata,
	output logic [1:0]                  m_tuser
);
	import vdphp_pkg::*;

	localparam int MemW  = $clog2(VRAM_DEPTH);
	localparam int ColW  = $clog2(COLS_PER_LINE);
	localparam int LineW = $clog2(LINES_PER_FRAME);
	localparam int RemW  = AddrW + 4;

	logic [AddrW-1:0] addr_q;
	logic [ByteW-1:0] read_ahead_q;
	logic [ByteW-1:0] latch_q;
	logic             second_due_q;
	logic             int_en_q;
	logic             int_flag_q;
	logic [ColW-1:0]  col_q;
	logic [LineW-1:0] line_q;
	logic [ByteW-1:0] rdata_q;
	logic [1:0]       user_q;

	logic [AddrW-1:0] set_addr;
	logic [AddrW-1:0] fetch_addr;
	logic             is_ctrl_second;
	logic [ColW:0]    col_inc;
	logic [LineW:0]   line_inc;
	logic [ColW-1:0]  col_next;
	logic [LineW-1:0] line_next;
	logic             nmi;
	logic             fend;
	logic [ByteW-1:0] rd;
	logic             vram_we;
	logic             vram_re;
	logic [MemW-1:0]  vram_addr;
	logic [ByteW-1:0] vram_rdata;

	// Memory entry of a 14-bit address: four restoring subtract steps,
	// since the depth is at least a sixteenth of the address range.
	function automatic logic [MemW-1:0] mem_index(input logic [AddrW-1:0] a);
		logic [RemW-1:0] r;
		r = RemW'(a);
		for (int k = 3; k >= 0; k--) begin
			if (r >= (RemW'(VRAM_DEPTH) << k)) begin
				r = r - (RemW'(VRAM_DEPTH) << k);
			end
		end
		return r[MemW-1:0];
	endfunction

	// Address step with wrap at the memory depth or at the top of the range.
	function automatic logic [AddrW-1:0] advance(input logic [AddrW-1:0] a);
		logic [AddrW-1:0] n;
		n = a + AddrW'(1);
		if ({1'b0, n} == (AddrW+1)'(VRAM_DEPTH)) begin
			n = '0;
		end
		return n;
	endfunction

	// Second control byte decoding.
	assign is_ctrl_second = (s_tuser == REQ_CTRL_WRITE) && second_due_q;
	assign set_addr       = {s_tdata[5:0], latch_q};
	assign stat.need_fetch = (s_tuser == REQ_DATA_READ) ||
		(is_ctrl_second && !s_tdata[7] && !s_tdata[6]);
	assign fetch_addr = (s_tuser == REQ_CTRL_WRITE) ? set_addr : addr_q;

	// Memory access on the accepted word.
	assign vram_re   = cmd.accept && stat.need_fetch;
	assign vram_we   = cmd.accept && (s_tuser == REQ_DATA_WRITE);
	assign vram_addr = mem_index(fetch_addr);

	vdphp_vram #(
		.VRAM_DEPTH(VRAM_DEPTH)
	) u_vram (
		.clk   (clk),
		.we    (vram_we),
		.re    (vram_re),
		.addr  (vram_addr),
		.wdata (s_tdata),
		.rdata (vram_rdata)
	);

	// Raster step for a tick.
	always_comb begin
		col_inc   = {1'b0, col_q} + (ColW+1)'(1);
		line_inc  = {1'b0, line_q} + (LineW+1)'(1);
		col_next  = col_inc[ColW-1:0];
		line_next = line_q;
		if (col_inc >= (ColW+1)'(COLS_PER_LINE)) begin
			col_next = '0;
			if (line_inc >= (LineW+1)'(LINES_PER_FRAME)) begin
				line_next = '0;
			end else begin
				line_next = line_inc[LineW-1:0];
			end
		end
	end

	// Result fields of the offered word.
	always_comb begin
		rd   = '0;
		nmi  = 1'b0;
		fend = 1'b0;
		case (s_tuser)
			REQ_TICK: begin
				nmi = (col_next == ColW'(1)) && (line_next == LineW'(VblankLine)) &&
					!int_flag_q && int_en_q;
				fend = (col_next == '0) && (line_next == LineW'(FrameEndLine));
			end
			REQ_DATA_READ: begin
				rd = read_ahead_q;
			end
			REQ_STAT_READ: begin
				rd = {int_flag_q, 7'd0};
			end
			default: begin
				rd = '0;
			end
		endcase
	end

	// Host port and raster state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			read_ahead_q <= '0;
			latch_q      <= '0;
			second_due_q <= 1'b0;
			int_en_q     <= 1'b0;
			int_flag_q   <= 1'b0;
			col_q        <= '0;
			line_q       <= '0;
		end else if (cmd.capture) begin
			read_ahead_q <= vram_rdata;
		end else if (cmd.accept) begin
			case (s_tuser)
				REQ_TICK: begin
					col_q  <= col_next;
					line_q <= line_next;
					if ((col_next == ColW'(1)) && (line_next == LineW'(VblankLine))) begin
						int_flag_q <= 1'b1;
					end
				end
				REQ_DATA_READ: begin
					addr_q <= advance(addr_q);
				end
				REQ_STAT_READ: begin
					second_due_q <= 1'b0;
					int_flag_q   <= 1'b0;
				end
				REQ_DATA_WRITE: begin
					read_ahead_q <= s_tdata;
					addr_q       <= advance(addr_q);
				end
				REQ_CTRL_WRITE: begin
					if (!second_due_q) begin
						latch_q      <= s_tdata;
						second_due_q <= 1'b1;
					end else begin
						second_due_q <= 1'b0;
						if (s_tdata[7]) begin
							// Only the interrupt enable of mode register 1 acts here.
							if (s_tdata[2:0] == REG_IE) begin
								int_en_q <= latch_q[5];
							end
						end else if (!s_tdata[6]) begin
							addr_q <= advance(set_addr);
						end else begin
							addr_q <= set_addr;
						end
					end
				end
				default: begin
					addr_q <= addr_q;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rdata_q <= rd;
			user_q  <= {fend, nmi};
		end
	end

	assign m_tdata = rdata_q;
	assign m_tuser = user_q;

endmodule

// ===== src/vdp_host_port_and_frame_timing_unit.sv =====
// Result word appears in the cycle after its input word is accepted.
// Ticks, status reads, data writes and plain control writes: one word per cycle
// while results drain; data reads and read-setup control writes add a VRAM wait.
// The next word is accepted while a result waits, if the result register is freed.
// Asynchronous active-low reset clears all control state; VRAM is not cleared.
// ----------------------------------------------------------------------------
// vdp_host_port_and_frame_timing_unit
// Host data/control port and raster timing of a video display processor.
// ----------------------------------------------------------------------------
module vdp_host_port_and_frame_timing_unit #(
	parameter int VRAM_DEPTH      = vdphp_pkg::VramDepthDef,
	parameter int COLS_PER_LINE   = vdphp_pkg::ColsPerLineDef,
	parameter int LINES_PER_FRAME = vdphp_pkg::LinesPerFrameDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [vdphp_pkg::ByteW-1:0] s_tdata,  // [7:0] port_value
	input  logic [vdphp_pkg::ReqW-1:0]  s_tuser,  // [2:0] req_type
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [vdphp_pkg::ByteW-1:0] m_tdata,  // [7:0] read_data
	output logic [1:0]                  m_tuser   // [0] nmi_pulse, [1] frame_end
);
	import vdphp_pkg::*;

	cmd_t    cmd;
	status_t stat;

	// Handshake and sequencing.
	vdphp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Port state, raster and memory.
	vdphp_datapath #(
		.VRAM_DEPTH      (VRAM_DEPTH),
		.COLS_PER_LINE   (COLS_PER_LINE),
		.LINES_PER_FRAME (LINES_PER_FRAME)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
